>>> src/modinv_pkg.sv
// modinv_pkg: shared widths, constants and sequencer states for the
// fermat modular inverse block; no dependencies
package modinv_pkg;

  localparam int VALUE_W       = 256;
  localparam int LIMB_W        = 64;
  localparam int OFFSET_W      = 60;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 60'd189;

  // digit width of the serial multiplier and steps per product
  localparam int DIGIT_W       = 4;
  localparam int MUL_STEPS     = VALUE_W / DIGIT_W;

  // low exponent word holds NOT(c + 1), the upper bits are all ones
  localparam int EXP_LOW_W     = 64;

  localparam int TABLE_ENTRIES_DEF = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G1_GO,
    ST_G1_WAIT,
    ST_TBL_GO,
    ST_TBL_WAIT,
    ST_WIN_INIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_RD,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_FIN
  } state_t;

endpackage

>>> src/modinv_ram.sv
// modinv_ram: generic single write port ram with registered read
// no dependencies
module modinv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/modinv_mul.sv
// modinv_mul: digit serial modular multiplier mod 2^256 - c, msb digit first
// depends on modinv_pkg
module modinv_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [modinv_pkg::VALUE_W-1:0]    op_a,
  input  logic [modinv_pkg::VALUE_W-1:0]    op_b,
  input  logic [modinv_pkg::OFFSET_W-1:0]   offset,
  output logic                              done,
  output logic [modinv_pkg::VALUE_W-1:0]    result
);

  localparam int VW = modinv_pkg::VALUE_W;
  localparam int DW = modinv_pkg::DIGIT_W;
  localparam int CW = modinv_pkg::OFFSET_W;
  localparam int SW = modinv_pkg::MUL_STEPS;
  localparam int NW = $clog2(SW);

  logic          busy;
  logic          fin;
  logic [NW-1:0] cnt;
  logic [VW-1:0] acc;
  logic [VW-1:0] a_sh;
  logic [VW-1:0] b;

  logic [DW-1:0]    dig;
  logic [VW+DW-1:0] db;
  logic [VW+DW:0]   v;
  logic [DW:0]      hi;
  logic [DW+CW:0]   hc;
  logic [VW:0]      s;
  logic [VW-1:0]    acc_next;
  logic [VW:0]      fsum;

  assign dig = a_sh[VW-1 -: DW];

  // partial products of the digit, summed
  always_comb begin
    db = '0;
    for (int i = 0; i < DW; i++) begin
      if (dig[i]) db = db + ((VW+DW)'(b) << i);
    end
  end

  // acc*16 + d*b, then fold the bits above 2^256 back in as hi*c
  always_comb begin
    v        = (VW+DW+1)'({acc, {DW{1'b0}}}) + (VW+DW+1)'(db);
    hi       = v[VW+DW:VW];
    hc       = (DW+CW+1)'(hi) * (DW+CW+1)'(offset);
    s        = (VW+1)'(v[VW-1:0]) + (VW+1)'(hc);
    acc_next = s[VW-1:0] + (s[VW] ? VW'(offset) : '0);
  end

  // acc >= p exactly when acc + c carries out
  assign fsum = (VW+1)'(acc) + (VW+1)'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= '0;
      end else if (busy && !fin) begin
        cnt <= cnt + NW'(1);
        if (cnt == NW'(SW-1)) fin <= 1'b1;
      end else if (fin) begin
        fin  <= 1'b0;
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc  <= '0;
      a_sh <= op_a;
      b    <= op_b;
    end else if (busy && !fin) begin
      acc  <= acc_next;
      a_sh <= a_sh << DW;
    end else if (fin) begin
      result <= fsum[VW] ? fsum[VW-1:0] : acc;
    end
  end

endmodule

>>> src/modular_inverse_fermat_256.sv
// modular_inverse_fermat_256: top level of the fermat inverse mod 2^256 - c
// depends on modinv_pkg, modinv_ram, modinv_mul
//
// usage
//   s_* channel takes one 256-bit value per transaction, s_tdata holds
//   value_limb0..value_limb3 from the lowest bits up. m_* returns the
//   inverse a^(p-2) mod p, fully reduced, as inverse_limb0..inverse_limb3.
//   cfg_we/cfg_wdata write modulus_offset c; write only while idle.
// operation
//   a is reduced mod p, the powers a^0..a^(2^w - 1) go into a small ram
//   (w the window width), then fixed-window exponentiation scans p-2
//   from the top. every product runs through one shared digit serial
//   multiplier taking 4 bits of an operand per cycle.
// products
//   1 + (2^w - 2) + windows*(w+1) products, 335 at 16 entries; one value
//   is in work at a time
// reset
//   rst clears the sequencer and output valid, c returns to 189
// stall
//   the result sits in the output register until m_tready; the next
//   value may be taken meanwhile, its result waits for the register to free
module modular_inverse_fermat_256 #(
  parameter int TABLE_ENTRIES = modinv_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [modinv_pkg::VALUE_W-1:0]  s_tdata,  // value_limb0..value_limb3
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [modinv_pkg::VALUE_W-1:0]  m_tdata,  // inverse_limb0..inverse_limb3
  input  logic                            cfg_we,
  input  logic [modinv_pkg::OFFSET_W-1:0] cfg_wdata  // modulus_offset
);

  localparam int VW   = modinv_pkg::VALUE_W;
  localparam int CW   = modinv_pkg::OFFSET_W;
  localparam int ELW  = modinv_pkg::EXP_LOW_W;
  // window width: floor(log2(entries)), capped at 6
  localparam int WB   = ($clog2(TABLE_ENTRIES + 1) - 1 > 6) ? 6
                        : $clog2(TABLE_ENTRIES + 1) - 1;
  localparam int ENT  = 1 << WB;
  localparam int AW   = WB;
  localparam int NWIN = (VW + WB - 1) / WB;
  localparam int EW   = NWIN * WB;
  localparam int KW   = $clog2(NWIN + 1);
  localparam int QW   = $clog2(WB + 1);

  modinv_pkg::state_t state, state_next;

  logic [CW-1:0] offset;
  logic [VW-1:0] a_val;
  logic [VW-1:0] g1;
  logic [VW-1:0] prev;
  logic [VW-1:0] r;
  logic [EW-1:0] e_sh;
  logic [AW-1:0] tidx;
  logic [KW-1:0] win_cnt;
  logic [QW-1:0] sq_cnt;

  logic          accept;
  logic          mul_start;
  logic          mul_done;
  logic [VW-1:0] mul_a;
  logic [VW-1:0] mul_b;
  logic [VW-1:0] mul_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [VW-1:0] ram_rdata;
  logic [ELW-1:0] cp1;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == modinv_pkg::ST_IDLE);
  // exponent low word is NOT(c + 1)
  assign cp1      = ELW'(offset) + ELW'(1);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= modinv_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modinv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, multiplier operands and table writes
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = r;
    mul_b      = r;
    ram_we     = 1'b0;
    ram_waddr  = tidx + AW'(1);
    ram_wdata  = mul_res;
    unique case (state)
      modinv_pkg::ST_IDLE: begin
        if (accept) begin
          // entry 0 is the power a^0
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = VW'(1);
          state_next = modinv_pkg::ST_G1_GO;
        end
      end
      modinv_pkg::ST_G1_GO: begin
        // a * 1 brings a below p
        mul_start  = 1'b1;
        mul_a      = a_val;
        mul_b      = VW'(1);
        state_next = modinv_pkg::ST_G1_WAIT;
      end
      modinv_pkg::ST_G1_WAIT: begin
        if (mul_done) begin
          ram_we     = 1'b1;
          ram_waddr  = AW'(1);
          state_next = (ENT == 2) ? modinv_pkg::ST_WIN_INIT : modinv_pkg::ST_TBL_GO;
        end
      end
      modinv_pkg::ST_TBL_GO: begin
        mul_start  = 1'b1;
        mul_a      = prev;
        mul_b      = g1;
        state_next = modinv_pkg::ST_TBL_WAIT;
      end
      modinv_pkg::ST_TBL_WAIT: begin
        if (mul_done) begin
          ram_we     = 1'b1;
          state_next = (tidx + AW'(1) == AW'(ENT - 1)) ? modinv_pkg::ST_WIN_INIT
                       : modinv_pkg::ST_TBL_GO;
        end
      end
      modinv_pkg::ST_WIN_INIT: begin
        state_next = modinv_pkg::ST_SQ_GO;
      end
      modinv_pkg::ST_SQ_GO: begin
        mul_start  = 1'b1;
        state_next = modinv_pkg::ST_SQ_WAIT;
      end
      modinv_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          state_next = (sq_cnt == QW'(WB - 1)) ? modinv_pkg::ST_RD : modinv_pkg::ST_SQ_GO;
        end
      end
      modinv_pkg::ST_RD: begin
        state_next = modinv_pkg::ST_MUL_GO;
      end
      modinv_pkg::ST_MUL_GO: begin
        mul_start  = 1'b1;
        mul_b      = ram_rdata;
        state_next = modinv_pkg::ST_MUL_WAIT;
      end
      modinv_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = (win_cnt == KW'(1)) ? modinv_pkg::ST_FIN : modinv_pkg::ST_SQ_GO;
        end
      end
      modinv_pkg::ST_FIN: begin
        if (!m_tvalid || m_tready) state_next = modinv_pkg::ST_IDLE;
      end
      default: begin
        state_next = modinv_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_val <= s_tdata;
      e_sh  <= EW'({{(VW - ELW){1'b1}}, ~cp1});
    end
    if (state == modinv_pkg::ST_G1_WAIT && mul_done) begin
      g1   <= mul_res;
      prev <= mul_res;
      tidx <= AW'(1);
    end
    if (state == modinv_pkg::ST_TBL_WAIT && mul_done) begin
      prev <= mul_res;
      tidx <= tidx + AW'(1);
    end
    if (state == modinv_pkg::ST_WIN_INIT) begin
      r       <= VW'(1);
      win_cnt <= KW'(NWIN);
      sq_cnt  <= '0;
    end
    if (state == modinv_pkg::ST_SQ_WAIT && mul_done) begin
      r      <= mul_res;
      sq_cnt <= (sq_cnt == QW'(WB - 1)) ? '0 : sq_cnt + QW'(1);
    end
    if (state == modinv_pkg::ST_MUL_GO) begin
      e_sh <= e_sh << WB;
    end
    if (state == modinv_pkg::ST_MUL_WAIT && mul_done) begin
      r       <= mul_res;
      win_cnt <= win_cnt - KW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == modinv_pkg::ST_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == modinv_pkg::ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= r;
    end
  end

  // power table, read at the current window digit
  modinv_ram #(
    .WIDTH (VW),
    .DEPTH (ENT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (e_sh[EW-1 -: WB]),
    .rdata (ram_rdata)
  );

  modinv_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .offset (offset),
    .done   (mul_done),
    .result (mul_res)
  );

endmodule

>>> src/modinv_chk.sv
// modinv_chk: port level checks of the fermat inverse block
// depends on modinv_pkg; bound to modular_inverse_fermat_256
module modinv_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [modinv_pkg::VALUE_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // a taken value keeps the input closed for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open right after a transaction");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind modular_inverse_fermat_256 modinv_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for modular_inverse_fermat_256, a^(p-2) mod 2^256 - c
// depends on modinv_pkg and the block's rtl; its own predictor does the power
module tb;

  localparam int HOLD_CYCLES = 60000;
  localparam int STALL_LIMIT = 200000;

  typedef logic [modinv_pkg::VALUE_W-1:0] value_t;
  typedef logic [modinv_pkg::OFFSET_W-1:0] offset_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  value_t s_tdata;
  logic m_tvalid;
  logic m_tready;
  value_t m_tdata;
  logic cfg_we;
  offset_t cfg_wdata;

  modular_inverse_fermat_256 u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  value_t pending_values[$];
  value_t expected_inverses[$];
  offset_t offset_c;
  logic value_taken;
  logic quiet;
  int hold_left;
  int results_seen;
  int mismatches;
  int idle_cycles;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // x mod (2^256 - c), fully reduced
  function automatic value_t reduce_mod(logic [511:0] x, offset_t c);
    logic [256:0] s;
    while (x[511:256] != '0)
      x = {256'd0, x[255:0]} + x[511:256] * {452'd0, c};
    s = {1'b0, x[255:0]} + {197'd0, c};
    return s[256] ? s[255:0] : x[255:0];
  endfunction

  function automatic value_t mul_mod(value_t a, value_t b, offset_t c);
    logic [511:0] prod;
    prod = {256'd0, a} * {256'd0, b};
    return reduce_mod(prod, c);
  endfunction

  // fixed 4-bit window power, exponent NOT(c + 1) = p - 2
  function automatic value_t fermat_inverse(value_t a, offset_t c);
    value_t powers[16];
    value_t r;
    value_t e;
    e = ~({196'd0, c} + 256'd1);
    powers[0] = 256'd1;
    powers[1] = reduce_mod({256'd0, a}, c);
    for (int i = 2; i < 16; i++) powers[i] = mul_mod(powers[i-1], powers[1], c);
    r = 256'd1;
    for (int k = 63; k >= 0; k--) begin
      for (int b = 0; b < 4; b++) r = mul_mod(r, r, c);
      r = mul_mod(r, powers[e[k*4 +: 4]], c);
    end
    return r;
  endfunction

  function automatic value_t random_value();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // sender: new transaction offered at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else if (!s_tvalid || value_taken) begin
      value_taken = 1'b0;
      if (pending_values.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_values.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random ready plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen == 3) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || $urandom_range(99) >= 6;
    end
  end

  // input side: predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_inverses.push_back(fermat_inverse(s_tdata, offset_c));
      value_taken = 1'b1;
    end
  end

  // output side: limb-by-limb compare against the oldest expectation
  always @(posedge clk) begin
    value_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction out: %h", m_tdata);
      end else begin
        want = expected_inverses.pop_front();
        for (int l = 0; l < 4; l++) begin
          if (m_tdata[l*modinv_pkg::LIMB_W +: modinv_pkg::LIMB_W] !==
              want[l*modinv_pkg::LIMB_W +: modinv_pkg::LIMB_W]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("inverse_limb%0d: expected %h, got %h", l,
                       want[l*modinv_pkg::LIMB_W +: modinv_pkg::LIMB_W],
                       m_tdata[l*modinv_pkg::LIMB_W +: modinv_pkg::LIMB_W]);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // checked at the rising edge so a freshly offered value is seen
  task automatic wait_idle();
    @(posedge clk);
    while (pending_values.size() != 0 || s_tvalid || expected_inverses.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_offset(offset_t c);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    offset_c = c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_directed();
    value_t p;
    p = 256'd0 - {196'd0, offset_c};
    pending_values.push_back(256'd0);
    pending_values.push_back(256'd1);
    pending_values.push_back(256'd2);
    pending_values.push_back(p - 256'd1);
    pending_values.push_back(p);
    pending_values.push_back(p + 256'd1);
    pending_values.push_back({modinv_pkg::VALUE_W{1'b1}});
    pending_values.push_back({4{64'hAAAA_AAAA_5555_5555}});
  endtask

  task automatic queue_random(int n);
    value_t p;
    p = 256'd0 - {196'd0, offset_c};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: pending_values.push_back(p - value_t'($urandom_range(1000)));
        1: pending_values.push_back(p + value_t'($urandom_range(20)));
        2: pending_values.push_back(value_t'($urandom));
        default: pending_values.push_back(random_value());
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    offset_c = modinv_pkg::OFFSET_RESET;
    value_taken = 1'b0;
    quiet = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    results_seen = 0;
    mismatches = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset value of c first, then the extremes, a random one and the reset value again
    queue_directed();
    queue_random(20);
    wait_idle();
    write_offset(60'd1);
    queue_directed();
    queue_random(20);
    wait_idle();
    write_offset(60'hFFF_FFFF_FFFF_FFFD);
    queue_directed();
    quiet = 1'b1;
    queue_random(20);
    wait_idle();
    quiet = 1'b0;
    write_offset(60'($urandom) | (60'($urandom_range(2**27 - 1)) << 32) | 60'd1);
    queue_random(18);
    wait_idle();
    write_offset(modinv_pkg::OFFSET_RESET);
    queue_random(18);
    wait_idle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
